[rtl/brrip_pkg.sv]
// shared constants and types for the block run resize table
package brrip_pkg;

	// table geometry
	localparam int BLOCK_COUNT = 128;
	localparam int BLOCK_BYTES = 1024;
	localparam int MAX_RUN     = 5;

	localparam int IDX_W    = $clog2(BLOCK_COUNT);
	localparam int POS_W    = IDX_W + 1;
	localparam int RUN_W    = 3;
	localparam int BYTES_W  = 16;
	localparam int SUM_W    = BYTES_W + 1;
	localparam int BB_SHIFT = $clog2(BLOCK_BYTES);
	localparam int NEED_W   = SUM_W - BB_SHIFT;
	localparam int CMP_W    = NEED_W + RUN_W;

	// item kinds
	localparam logic KIND_RESIZE = 1'b0;
	localparam logic KIND_WRITE  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RELOCATE = 2'd1,
		ST_BAD_HEAD = 2'd2,
		ST_WRITTEN  = 2'd3
	} status_t;

	// one table entry
	typedef struct packed {
		logic             free;
		logic [RUN_W-1:0] run;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// value of an entry that was never written
	localparam entry_t RST_ENTRY = '{free: 1'b1, run: '0};

endpackage

[rtl/block_run_resize_in_place.sv]
// block run resize table: takes a table write or a request to resize a block run in place
// one word at a time: accept, head lookup, then a scan of up to MAX_RUN - 1 following
// entries, each a ram read and then a check, then up to seven entry writes, one a cycle
// a new word can be taken in the cycle that its result first shows in the output register;
// a result held there by out_stall delays the next word
// reset clears the entry valid bits at once, so every entry reads as free with run 0;
// no clearing pass, an item can be accepted in the first cycle after reset
module block_run_resize_in_place (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 kind,
	input  logic [brrip_pkg::IDX_W-1:0]          index,
	input  logic [brrip_pkg::BYTES_W-1:0]        request_bytes,
	input  logic                                 entry_free,
	input  logic [brrip_pkg::RUN_W-1:0]          entry_run,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic [brrip_pkg::RUN_W-1:0]          blocks_now
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_SCAN_RD,
		S_SCAN_CK,
		S_WRITE,
		S_DONE
	} state_t;

	localparam int CW = brrip_pkg::CMP_W;
	localparam int PW = brrip_pkg::POS_W;
	localparam int IW = brrip_pkg::IDX_W;
	localparam int RW = brrip_pkg::RUN_W;
	localparam int NW = brrip_pkg::NEED_W;
	localparam int SW = brrip_pkg::SUM_W;

	state_t                           st_q;
	logic [IW-1:0]                    head_q;
	logic [NW-1:0]                    need_q;
	logic                             zero_q;
	logic [RW-1:0]                    j_q;
	logic [RW-1:0]                    k_q;
	logic [RW-1:0]                    cnt_q;
	logic [brrip_pkg::BLOCK_COUNT-1:0] vld_q;
	logic                             rd_vld_q;
	brrip_pkg::status_t               res_st_q;
	logic [RW-1:0]                    res_now_q;
	logic                             out_valid_q;
	brrip_pkg::status_t               out_st_q;
	logic [RW-1:0]                    out_now_q;

	logic                             in_acc;
	logic [SW-1:0]                    need_sum;
	logic [NW-1:0]                    need_d;
	logic [PW-1:0]                    pos_scan;
	logic [PW-1:0]                    pos_wr;
	logic                             scan_go;
	logic                             scan_hit;
	logic                             out_free;
	brrip_pkg::entry_t                rd_ent;
	logic [brrip_pkg::ENTRY_W-1:0]    rd_data;
	logic                             ram_we;
	logic [IW-1:0]                    ram_waddr;
	brrip_pkg::entry_t                ram_wdata;
	logic [IW-1:0]                    ram_raddr;

	// handshake
	assign in_stall = (st_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// byte size to block count, rounded up
	assign need_sum = SW'({1'b0, request_bytes}) + SW'(brrip_pkg::BLOCK_BYTES - 1);
	assign need_d   = need_sum[SW-1:brrip_pkg::BB_SHIFT];

	// table positions for the scan and the write sweep
	assign pos_scan = PW'(head_q) + PW'(j_q);
	assign pos_wr   = PW'(head_q) + PW'(k_q);

	// entry as read, unwritten entries read as the reset value
	assign rd_ent = rd_vld_q ? brrip_pkg::entry_t'(rd_data) : brrip_pkg::RST_ENTRY;

	// growth scan continues while in range, under the max run and short of need
	assign scan_go = (pos_scan < PW'(brrip_pkg::BLOCK_COUNT))
		&& (CW'(j_q) < CW'(brrip_pkg::MAX_RUN))
		&& (CW'(j_q) < CW'(need_q));
	assign scan_hit = (CW'(j_q) == CW'(need_q));

	// ram port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = index;
		ram_wdata = '{free: entry_free, run: entry_run};
		ram_raddr = (st_q == S_IDLE) ? index : pos_scan[IW-1:0];
		if (st_q == S_IDLE) begin
			ram_we = in_acc && (kind == brrip_pkg::KIND_WRITE);
		end else if (st_q == S_WRITE) begin
			ram_we    = (pos_wr < PW'(brrip_pkg::BLOCK_COUNT));
			ram_waddr = pos_wr[IW-1:0];
			if (CW'(k_q) < CW'(need_q)) begin
				ram_wdata.free = 1'b0;
				ram_wdata.run  = (k_q == '0) ? need_q[RW-1:0] : '0;
			end else begin
				ram_wdata = brrip_pkg::RST_ENTRY;
			end
		end
	end

	brrip_ram #(
		.W     (brrip_pkg::ENTRY_W),
		.DEPTH (brrip_pkg::BLOCK_COUNT)
	) u_tbl (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// sequencer, valid bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			vld_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_st_q    <= brrip_pkg::ST_OK;
			out_now_q   <= '0;
			head_q      <= '0;
			need_q      <= '0;
			zero_q      <= 1'b0;
			j_q         <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			res_st_q    <= brrip_pkg::ST_OK;
			res_now_q   <= '0;
		end else begin
			rd_vld_q <= vld_q[ram_raddr];
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			// output register loads a finished word and clears when taken
			if (st_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
				out_st_q    <= res_st_q;
				out_now_q   <= res_now_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						head_q <= index;
						need_q <= need_d;
						zero_q <= (request_bytes == '0);
						if (kind == brrip_pkg::KIND_WRITE) begin
							res_st_q  <= brrip_pkg::ST_WRITTEN;
							res_now_q <= entry_run;
							st_q      <= S_DONE;
						end else begin
							st_q <= S_HEAD;
						end
					end
				end
				S_HEAD: begin
					j_q <= rd_ent.run;
					k_q <= '0;
					if (rd_ent.run == '0 || rd_ent.free) begin
						res_st_q  <= brrip_pkg::ST_BAD_HEAD;
						res_now_q <= rd_ent.run;
						st_q      <= S_DONE;
					end else if (zero_q) begin
						res_st_q  <= brrip_pkg::ST_RELOCATE;
						res_now_q <= rd_ent.run;
						st_q      <= S_DONE;
					end else if (CW'(need_q) <= CW'(rd_ent.run)) begin
						// shrink: release the old run and mark the new one in one sweep
						cnt_q     <= rd_ent.run;
						res_st_q  <= brrip_pkg::ST_OK;
						res_now_q <= need_q[RW-1:0];
						st_q      <= S_WRITE;
					end else begin
						res_now_q <= rd_ent.run;
						st_q      <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					if (scan_go) begin
						st_q <= S_SCAN_CK;
					end else if (scan_hit) begin
						cnt_q     <= need_q[RW-1:0];
						res_st_q  <= brrip_pkg::ST_OK;
						res_now_q <= need_q[RW-1:0];
						st_q      <= S_WRITE;
					end else begin
						res_st_q <= brrip_pkg::ST_RELOCATE;
						st_q     <= S_DONE;
					end
				end
				S_SCAN_CK: begin
					if (rd_ent.free) begin
						j_q  <= j_q + RW'(1);
						st_q <= S_SCAN_RD;
					end else begin
						res_st_q <= brrip_pkg::ST_RELOCATE;
						st_q     <= S_DONE;
					end
				end
				S_WRITE: begin
					k_q <= k_q + RW'(1);
					if (k_q == cnt_q - RW'(1)) begin
						st_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_st_q;
	assign blocks_now = out_now_q;

	// an accepted word keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after accepting a word");

	// an in-place resize always leaves a nonzero run
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == brrip_pkg::ST_OK) |-> (blocks_now != '0))
		else $error("resize reported ok with empty run");

	// the write sweep stays inside its count
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_WRITE) |-> (k_q < cnt_q))
		else $error("write sweep ran past its count");

	// the growth scan never checks an entry at or beyond the max run
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_SCAN_CK) |-> (CW'(j_q) < CW'(brrip_pkg::MAX_RUN)))
		else $error("growth scan beyond max run");

endmodule

[rtl/brrip_ram.sv]
// generic single write port ram with registered read
module brrip_ram #(
	parameter int W     = 4,
	parameter int DEPTH = 128,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
